### hw/rtl/swrm_pkg.sv
// package: shared types and constants for the sliding window rate monitor
`timescale 1ns / 1ps
`default_nettype none
package swrm_pkg;

  localparam int WindowDepth = 1024;
  localparam int SlotW       = $clog2(WindowDepth);
  localparam int WinW        = 11;

  localparam logic [63:0] PerfScale  = 64'd65536000000000;
  localparam logic [63:0] PowerScale = 64'd65536000;
  localparam logic [63:0] PosMax     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegMax     = 64'h8000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_UPDATE, ST_MUL_LO, ST_MUL_HI,
    ST_DIV, ST_STORE, ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] work;
    logic [63:0] t_begin;
    logic [63:0] t_finish;
    logic [63:0] e_begin;
    logic [63:0] e_finish;
  } beat_in_t;

  typedef struct packed {
    logic [63:0]      beat_id;
    logic [SlotW-1:0] slot;
    logic             window_complete;
    logic [63:0]      perf_total;
    logic [63:0]      perf_win;
    logic [63:0]      perf_beat;
    logic [63:0]      global_power;
    logic [63:0]      window_power;
    logic [63:0]      instant_power;
  } beat_out_t;

endpackage
`default_nettype wire

### hw/rtl/swrm_if.sv
// interfaces: valid/ready channels for beats in and results out
`timescale 1ns / 1ps
`default_nettype none
interface swrm_in_if;
  logic                valid;
  logic                ready;
  swrm_pkg::beat_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface swrm_out_if;
  logic                valid;
  logic                ready;
  swrm_pkg::beat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/swrm_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module swrm_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### hw/rtl/sliding_window_rate_monitor.sv
// top level: sliding window rate monitor
`timescale 1ns / 1ps
`default_nettype none
// Each accepted beat adds its work, time delta and energy delta to 64-bit global sums and to
// sums over the last window-length beats, held in a 1024-entry ring, and returns one result
// with six Q47.16 ratios (work*1e9/time, energy*1000/time; saturating). After reset and after
// every write of the window length the ring is cleared by a pass over all 1024 entries during
// which no beat is taken. Each ratio builds its 128-bit scaled numerator from four partial
// products of one shared 32x32 multiplier, one per cycle, then one shared restoring divider
// produces one quotient bit per cycle; a ratio with a zero numerator or denominator skips
// both and is set directly. The result sits in an output register; the next beat is taken
// once it has been delivered, so beats are never overlapped.
module sliding_window_rate_monitor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [swrm_pkg::WinW-1:0]  cfg_wdata,
  swrm_in_if.sink                         in_ch,
  swrm_out_if.source                      out_ch
);
  import swrm_pkg::*;

  state_t state, state_next;
  logic [WinW-1:0]  win_len;
  logic [SlotW:0]   win_eff;
  logic [SlotW:0]   clr_cnt;
  logic [SlotW-1:0] write_slot, cur_slot;
  logic [63:0] beat_count, total_time, total_work, total_energy;
  logic [63:0] win_time, win_work, win_energy;
  logic [63:0] work_r, dt_r, de_r;
  logic [2:0]  ratio_idx;
  logic [63:0] res [6];
  logic        out_valid;
  beat_out_t   out_data;

  // ram
  logic             ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [63:0]      rd_time, rd_work, rd_energy;
  logic [63:0]      wr_time, wr_work, wr_energy;

  swrm_ram #(.Width(64), .Depth(WindowDepth)) u_ram_time (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(wr_time), .rdata(rd_time));
  swrm_ram #(.Width(64), .Depth(WindowDepth)) u_ram_work (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(wr_work), .rdata(rd_work));
  swrm_ram #(.Width(64), .Depth(WindowDepth)) u_ram_energy (
    .clk, .we(ram_we), .addr(ram_addr), .wdata(wr_energy), .rdata(rd_energy));

  always_comb begin
    if (win_len == '0) begin
      win_eff = (SlotW+1)'(1);
    end else if (win_len > WinW'(WindowDepth)) begin
      win_eff = (SlotW+1)'(WindowDepth);
    end else begin
      win_eff = (SlotW+1)'(win_len);
    end
    cur_slot = ({1'b0, write_slot} >= win_eff) ? '0 : write_slot;
  end

  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_STORE);
    ram_addr  = (state == ST_CLEAR) ? clr_cnt[SlotW-1:0] : cur_slot;
    wr_time   = (state == ST_CLEAR) ? '0 : dt_r;
    wr_work   = (state == ST_CLEAR) ? '0 : work_r;
    wr_energy = (state == ST_CLEAR) ? '0 : de_r;
  end

  // ratio operand selection
  logic        nneg, dneg;
  logic [63:0] nmag, dmag, num_sel, den_sel, scale_sel;
  logic        sgn_num;
  always_comb begin
    case (ratio_idx)
      3'd0:    begin num_sel = total_work;   den_sel = total_time; end
      3'd1:    begin num_sel = win_work;     den_sel = win_time;   end
      3'd2:    begin num_sel = work_r;       den_sel = dt_r;       end
      3'd3:    begin num_sel = total_energy; den_sel = total_time; end
      3'd4:    begin num_sel = win_energy;   den_sel = win_time;   end
      default: begin num_sel = de_r;         den_sel = dt_r;       end
    endcase
    sgn_num   = ratio_idx >= 3'd3;
    scale_sel = sgn_num ? PowerScale : PerfScale;
    nneg      = sgn_num && num_sel[63];
    nmag      = nneg ? 64'(0 - num_sel) : num_sel;
    dneg      = den_sel[63];
    dmag      = dneg ? 64'(0 - den_sel) : den_sel;
  end

  // shared 32x32 multiplier, partial products lo*lo, hi*lo, lo*hi, hi*hi in turn
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic [127:0] prod, mul_sh, prod_sum;
  logic [1:0]   mul_step;
  always_comb begin
    mul_a    = mul_step[0] ? nmag[63:32] : nmag[31:0];
    mul_b    = mul_step[1] ? scale_sel[63:32] : scale_sel[31:0];
    mul_p    = 64'(mul_a) * 64'(mul_b);
    mul_sh   = (mul_step == 2'd3) ? {mul_p, 64'd0} : {32'd0, mul_p, 32'd0};
    prod_sum = prod + mul_sh;
  end

  // restoring divider, one bit per cycle
  logic [127:0] dividend, quot;
  logic [63:0]  rem;
  logic [6:0]   bit_cnt;
  logic [64:0]  rem_sh;
  logic         take;
  always_comb begin
    rem_sh = {rem, dividend[127]};
    take   = rem_sh >= {1'b0, dmag};
  end

  logic [63:0] ratio_res;
  logic [127:0] q_fin;
  always_comb begin
    q_fin = {quot[126:0], take};
    if (nneg != dneg) begin
      ratio_res = (q_fin[127:64] != '0 || q_fin[63:0] > NegMax) ? NegMax
                : 64'(0 - q_fin[63:0]);
    end else begin
      ratio_res = (q_fin[127:64] != '0 || q_fin[63:0] > PosMax) ? PosMax : q_fin[63:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == (SlotW+1)'(WindowDepth - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_ch.valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_MUL_LO;
      ST_MUL_LO: begin
        if (nmag == '0 || dmag == '0) begin
          state_next = (ratio_idx == 3'd5) ? ST_STORE : ST_MUL_LO;
        end else begin
          state_next = ST_MUL_HI;
        end
      end
      ST_MUL_HI: if (mul_step == 2'd3) state_next = ST_DIV;
      ST_DIV:    if (bit_cnt == 7'd127) state_next = (ratio_idx == 3'd5) ? ST_STORE : ST_MUL_LO;
      ST_STORE:  state_next = ST_OUT;
      ST_OUT:    if (out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    if (cfg_we) state_next = ST_CLEAR;
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state == ST_IDLE) && !cfg_we;
    out_ch.valid = out_valid;
    out_ch.data  = out_data;
  end

  logic quick;
  logic [63:0] quick_res;
  always_comb begin
    quick     = (nmag == '0 || dmag == '0);
    quick_res = (nmag == '0) ? '0 : (nneg ? NegMax : PosMax);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      win_len     <= WinW'(WindowDepth);
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      write_slot  <= '0;
      beat_count  <= '0;
      total_time  <= '0; total_work <= '0; total_energy <= '0;
      win_time    <= '0; win_work   <= '0; win_energy   <= '0;
      ratio_idx   <= '0;
      mul_step    <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        win_len     <= cfg_wdata;
        clr_cnt     <= '0;
        out_valid   <= 1'b0;
        write_slot  <= '0;
        beat_count  <= '0;
        total_time  <= '0; total_work <= '0; total_energy <= '0;
        win_time    <= '0; win_work   <= '0; win_energy   <= '0;
      end else begin
        case (state)
          ST_CLEAR: clr_cnt <= clr_cnt + 1'b1;
          ST_IDLE: if (in_ch.valid) begin
            work_r <= in_ch.data.work;
            dt_r   <= in_ch.data.t_finish - in_ch.data.t_begin;
            de_r   <= in_ch.data.e_finish - in_ch.data.e_begin;
          end
          ST_READ: ;
          ST_UPDATE: begin
            total_time   <= total_time + dt_r;
            total_work   <= total_work + work_r;
            total_energy <= total_energy + de_r;
            win_time     <= win_time + dt_r - rd_time;
            win_work     <= win_work + work_r - rd_work;
            win_energy   <= win_energy + de_r - rd_energy;
            ratio_idx    <= '0;
            mul_step     <= '0;
          end
          ST_MUL_LO: begin
            if (quick) begin
              res[ratio_idx] <= quick_res;
              ratio_idx      <= ratio_idx + 1'b1;
            end else begin
              prod     <= {64'd0, mul_p};
              mul_step <= 2'd1;
            end
          end
          ST_MUL_HI: begin
            mul_step <= mul_step + 1'b1;
            if (mul_step == 2'd3) begin
              dividend <= prod_sum;
              rem      <= '0;
              quot     <= '0;
              bit_cnt  <= '0;
            end else begin
              prod <= prod_sum;
            end
          end
          ST_DIV: begin
            rem      <= take ? 64'(rem_sh - {1'b0, dmag}) : rem_sh[63:0];
            quot     <= {quot[126:0], take};
            dividend <= {dividend[126:0], 1'b0};
            bit_cnt  <= bit_cnt + 1'b1;
            if (bit_cnt == 7'd127) begin
              res[ratio_idx] <= ratio_res;
              ratio_idx      <= ratio_idx + 1'b1;
            end
          end
          ST_STORE: begin
            out_data.beat_id         <= beat_count;
            out_data.slot            <= cur_slot;
            out_data.window_complete <= ({1'b0, cur_slot} + 1'b1) >= win_eff;
            out_data.perf_total      <= res[0];
            out_data.perf_win        <= res[1];
            out_data.perf_beat       <= res[2];
            out_data.global_power    <= res[3];
            out_data.window_power    <= res[4];
            out_data.instant_power   <= res[5];
            out_valid                <= 1'b1;
            beat_count               <= beat_count + 1'b1;
            write_slot <= (({1'b0, cur_slot} + 1'b1) >= win_eff) ? '0 : cur_slot + 1'b1;
          end
          ST_OUT: if (out_ch.ready) out_valid <= 1'b0;
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/swrm_checker.sv
// checker: port level properties of the rate monitor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module swrm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_we,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] beat_id
);
  ap_out_hold: assert property (@(posedge clk) disable iff (rst || cfg_we)
    out_valid && !out_ready |=> out_valid && $stable(beat_id))
    else $error("result dropped while stalled");
  ap_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("beat taken while result pending");
  ap_take_then_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after transaction");
  ap_no_ready_in_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("active after reset");
endmodule

bind sliding_window_rate_monitor swrm_checker u_swrm_checker (
  .clk(clk), .rst(rst), .cfg_we(cfg_we),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .beat_id(out_ch.data.beat_id));
`default_nettype wire

### bench/tb_sliding_window_rate_monitor.sv
// testbench: sliding window rate monitor checked against a behavioural predictor
`timescale 1ns / 1ps
module tb_sliding_window_rate_monitor;
  import swrm_pkg::*;

  localparam int IdleLimit  = 20000;
  localparam int DrainWait  = 900;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  swrm_in_if  in_ch ();
  swrm_out_if out_ch ();

  sliding_window_rate_monitor dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  // predictor state
  logic [63:0] ring_time   [WindowDepth];
  logic [63:0] ring_work   [WindowDepth];
  logic [63:0] ring_energy [WindowDepth];
  int unsigned next_slot;
  logic [63:0] beat_num;
  logic [63:0] sum_time, sum_work, sum_energy;
  logic [63:0] wsum_time, wsum_work, wsum_energy;
  logic [10:0] win_setting;

  beat_out_t   pending_results[$];
  int          errors;
  int          idle_cycles;
  bit          quiet_phase;
  logic [63:0] clock_ns, energy_uj;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void clear_monitor_state();
    for (int i = 0; i < WindowDepth; i++) begin
      ring_time[i]   = '0;
      ring_work[i]   = '0;
      ring_energy[i] = '0;
    end
    next_slot = 0;
    beat_num  = '0;
    {sum_time, sum_work, sum_energy}    = '0;
    {wsum_time, wsum_work, wsum_energy} = '0;
  endfunction

  // numerator given as sign and magnitude, signed denominator, truncating and saturating
  function automatic logic [63:0] scaled_quotient(bit nneg, logic [63:0] nmag,
                                                  logic [63:0] den, logic [63:0] scale);
    logic [127:0] prod, quo;
    logic [63:0]  dmag;
    bit           neg;
    dmag = den[63] ? -den : den;
    if (nmag == 0) return '0;
    if (dmag == 0) return nneg ? NegMax : PosMax;
    prod = {64'b0, nmag} * {64'b0, scale};
    quo  = prod / {64'b0, dmag};
    neg  = nneg != den[63];
    if (neg) begin
      if (quo > {64'b0, NegMax}) return NegMax;
      return -quo[63:0];
    end
    if (quo > {64'b0, PosMax}) return PosMax;
    return quo[63:0];
  endfunction

  function automatic logic [63:0] signed_quotient(logic [63:0] num, logic [63:0] den,
                                                  logic [63:0] scale);
    return scaled_quotient(num[63], num[63] ? -num : num, den, scale);
  endfunction

  function automatic beat_out_t predict_rates(beat_in_t b);
    beat_out_t   r;
    logic [63:0] dt, de;
    int unsigned win, s;
    dt  = b.t_finish - b.t_begin;
    de  = b.e_finish - b.e_begin;
    win = 32'(win_setting);
    if (win == 0) win = 1;
    if (win > WindowDepth) win = WindowDepth;
    if (next_slot >= win) next_slot = 0;
    s = next_slot;
    sum_time    += dt;
    sum_work    += b.work;
    sum_energy  += de;
    wsum_time   += dt - ring_time[s];
    wsum_work   += b.work - ring_work[s];
    wsum_energy += de - ring_energy[s];
    ring_time[s]   = dt;
    ring_work[s]   = b.work;
    ring_energy[s] = de;
    r.beat_id         = beat_num;
    r.slot            = s[SlotW-1:0];
    r.perf_total      = scaled_quotient(1'b0, sum_work, sum_time, PerfScale);
    r.perf_win        = scaled_quotient(1'b0, wsum_work, wsum_time, PerfScale);
    r.perf_beat       = scaled_quotient(1'b0, b.work, dt, PerfScale);
    r.global_power    = signed_quotient(sum_energy, sum_time, PowerScale);
    r.window_power    = signed_quotient(wsum_energy, wsum_time, PowerScale);
    r.instant_power   = signed_quotient(de, dt, PowerScale);
    r.window_complete = (s + 1) >= win;
    beat_num++;
    next_slot = r.window_complete ? 0 : s + 1;
    return r;
  endfunction

  function automatic int gap_len();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // input side: a transaction completes on the edge where valid and ready are both high
  task automatic send_beat(beat_in_t b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_rates(b));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_window(logic [10:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_setting = value;
    clear_monitor_state();
  endtask

  // mostly plausible beats on a rising clock and meter, the rest raw bit patterns
  function automatic beat_in_t make_beat();
    beat_in_t b;
    if ($urandom_range(0, 9) < 7) begin
      b.work     = 64'($urandom_range(0, 1000000));
      b.t_begin  = clock_ns + $urandom_range(0, 1000);
      b.t_finish = b.t_begin + $urandom_range(0, 2000000);
      b.e_begin  = energy_uj + $urandom_range(0, 100);
      b.e_finish = b.e_begin + $urandom_range(0, 50000);
      clock_ns  = b.t_finish;
      energy_uj = b.e_finish;
    end else begin
      b.work     = rand64();
      b.t_begin  = rand64();
      b.t_finish = ($urandom_range(0, 3) == 0) ? b.t_begin : rand64();
      b.e_begin  = rand64();
      b.e_finish = rand64();
    end
    return b;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_beat(make_beat());
  endtask

  task automatic test_directed();
    beat_in_t b;
    b = '0;
    send_beat(b);                                   // all zero: zero over zero
    b.work = '1; b.t_finish = 64'd1;
    send_beat(b);                                   // largest work over 1 ns saturates
    b = '1;
    send_beat(b);                                   // all ones, zero deltas
    b = '0; b.t_begin = 64'd100; b.t_finish = 64'd40;
    b.work = 64'd5; b.e_finish = 64'd7;
    send_beat(b);                                   // time running backwards
    b = '0; b.t_finish = 64'd1000; b.e_begin = 64'd900; b.e_finish = 64'd10;
    send_beat(b);                                   // energy counter going down
    b = '0; b.work = 64'd12; b.e_begin = 64'd3; b.e_finish = 64'd3;
    send_beat(b);                                   // positive work over zero time
    b = '0; b.e_begin = 64'd8; b.e_finish = 64'd2;
    send_beat(b);                                   // negative energy over zero time
    b = '0; b.t_begin = '1; b.t_finish = 64'd999; b.work = 64'd1;
    b.e_begin = 64'h8000_0000_0000_0000; b.e_finish = 64'h7FFF_FFFF_FFFF_FFFF;
    send_beat(b);                                   // wrapping deltas
    b = '0; b.t_finish = 64'h7FFF_FFFF_FFFF_FFFF; b.work = 64'd1; b.e_finish = 64'd1;
    send_beat(b);                                   // tiny over huge rounds to zero
    b = '0; b.t_finish = 64'h8000_0000_0000_0000; b.work = '1;
    b.e_finish = 64'h8000_0000_0000_0000;
    send_beat(b);                                   // most negative time delta
    repeat (6) send_beat(make_beat());
  endtask

  task automatic test_window_extremes();
    write_window(11'd1);
    run_random(100);
    write_window(11'd0);                            // zero acts as one
    run_random(60);
    write_window(11'd2047);                         // clamped to the ring depth
    run_random(150);
    write_window(11'd1024);
    run_random(150);
  endtask

  task automatic test_window_wrap();
    write_window(11'd7);
    run_random(200);
    write_window(11'd2);
    run_random(80);
    write_window(11'd1023);
    run_random(60);
  endtask

  task automatic test_random_windows();
    repeat (6) begin
      write_window(11'($urandom_range(1, 40)));
      quiet_phase = $urandom_range(0, 2) == 0;
      run_random(80);
      quiet_phase = 1'b0;
    end
    write_window(11'($urandom_range(1025, 2047)));
    run_random(80);
  endtask

  // output side stalls
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    beat_out_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual beat_id %h", $time, a.beat_id);
      end else begin
        e = pending_results.pop_front();
        check_field("beat_id", e.beat_id, a.beat_id);
        check_field("slot", 64'(e.slot), 64'(a.slot));
        check_field("window_complete", 64'(e.window_complete), 64'(a.window_complete));
        check_field("perf_total", e.perf_total, a.perf_total);
        check_field("perf_win", e.perf_win, a.perf_win);
        check_field("perf_beat", e.perf_beat, a.perf_beat);
        check_field("global_power", e.global_power, a.global_power);
        check_field("window_power", e.window_power, a.window_power);
        check_field("instant_power", e.instant_power, a.instant_power);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    errors       = 0;
    idle_cycles  = 0;
    quiet_phase  = 1'b0;
    clock_ns     = '0;
    energy_uj    = '0;
    win_setting  = 11'd1024;
    clear_monitor_state();
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_directed();
    run_random(74);
    test_window_extremes();
    test_window_wrap();
    test_random_windows();
    wait_drained();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
